[src/tlpff_pkg.sv]
// Shared types and constants of the two-level page fault filler.
// Used by the channel interfaces, the controller, the datapath and the top level.
package tlpff_pkg;

    localparam int IDX_W   = 10;
    localparam int FRAME_W = 20;
    localparam int ENTRY_W = 32;

    // Operation codes of an input item.
    localparam logic OP_FILL      = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    // Configuration register index, taken from paddr[2].
    localparam logic REG_TABLE_FRAME_BASE = 1'b0;

    localparam logic [11:0]        FLAGS_PRESENT_RW = 12'h003;
    localparam logic [ENTRY_W-1:0] ENTRY_ABSENT     = 32'h0000_0002;
    localparam logic [FRAME_W-1:0] RESET_BASE       = 20'd512;
    localparam logic [ENTRY_W-1:0] RESET_DIR0       = {RESET_BASE, FLAGS_PRESENT_RW};

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DIR_RD,
        S_EVAL,
        S_CLEAR,
        S_MAP,
        S_TBL_RD,
        S_TBL_CAP,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_wr;
        logic capture;
        logic dir_rd;
        logic eval;
        logic clr_wr;
        logic map_wr;
        logic tbl_rd;
        logic te_cap;
        logic out_load;
        logic cnt_clr;
        logic cnt_inc;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_last;
        logic present;
        logic in_window;
        logic fill;
        logic out_free;
    } t_stat;

endpackage

[src/tlpff_in_if.sv]
// Input item channel of the page fault filler: valid, ready and the item fields.
// Depends on tlpff_pkg for field widths.
interface tlpff_in_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [31:0]                    fault_address;
    logic [tlpff_pkg::FRAME_W-1:0]  new_table_frame;
    logic [tlpff_pkg::FRAME_W-1:0]  new_page_frame;

    modport source (output valid, operation, fault_address, new_table_frame, new_page_frame,
                    input ready);
    modport sink (input valid, operation, fault_address, new_table_frame, new_page_frame,
                  output ready);
endinterface

[src/tlpff_out_if.sv]
// Result item channel of the page fault filler: valid, ready and the result fields.
// Depends on tlpff_pkg for field widths.
interface tlpff_out_if;
    logic                           valid;
    logic                           ready;
    logic [tlpff_pkg::ENTRY_W-1:0]  directory_entry;
    logic [tlpff_pkg::ENTRY_W-1:0]  table_entry;
    logic                           created_table;
    logic                           window_error;

    modport source (output valid, directory_entry, table_entry, created_table, window_error,
                    input ready);
    modport sink (input valid, directory_entry, table_entry, created_table, window_error,
                  output ready);
endinterface

[src/tlpff_ctrl.sv]
// Controller state machine of the page fault filler.
// Depends on tlpff_pkg for the state type and the command and status structs.
module tlpff_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tlpff_pkg::t_stat i_stat,
    output tlpff_pkg::t_cmd  o_cmd
);

    tlpff_pkg::t_state r_state;
    tlpff_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlpff_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tlpff_pkg::S_INIT: begin
                // Reset pass: directory defaults and the identity table in slot 0.
                o_cmd.init_wr = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = tlpff_pkg::S_IDLE;
                end
            end
            tlpff_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = tlpff_pkg::S_DIR_RD;
                end
            end
            tlpff_pkg::S_DIR_RD: begin
                o_cmd.dir_rd = 1'b1;
                n_state      = tlpff_pkg::S_EVAL;
            end
            tlpff_pkg::S_EVAL: begin
                o_cmd.eval    = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                if (i_stat.present) begin
                    if (!i_stat.in_window) begin
                        n_state = tlpff_pkg::S_DONE;
                    end else if (i_stat.fill) begin
                        n_state = tlpff_pkg::S_MAP;
                    end else begin
                        n_state = tlpff_pkg::S_TBL_RD;
                    end
                end else if (i_stat.fill && i_stat.in_window) begin
                    n_state = tlpff_pkg::S_CLEAR;
                end else begin
                    n_state = tlpff_pkg::S_DONE;
                end
            end
            tlpff_pkg::S_CLEAR: begin
                o_cmd.clr_wr  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = tlpff_pkg::S_MAP;
                end
            end
            tlpff_pkg::S_MAP: begin
                o_cmd.map_wr = 1'b1;
                n_state      = tlpff_pkg::S_DONE;
            end
            tlpff_pkg::S_TBL_RD: begin
                o_cmd.tbl_rd = 1'b1;
                n_state      = tlpff_pkg::S_TBL_CAP;
            end
            tlpff_pkg::S_TBL_CAP: begin
                o_cmd.te_cap = 1'b1;
                n_state      = tlpff_pkg::S_DONE;
            end
            tlpff_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = tlpff_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tlpff_pkg::S_INIT;
            end
        endcase
    end

endmodule

[src/tlpff_dpath.sv]
// Datapath of the page fault filler: directory and table memories, item registers,
// window check, sweep counter and the result register. Depends on tlpff_pkg.
module tlpff_dpath #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tlpff_pkg::t_cmd                i_cmd,
    output tlpff_pkg::t_stat               o_stat,
    input  logic [tlpff_pkg::FRAME_W-1:0]  i_base,
    input  logic                           i_operation,
    input  logic [31:0]                    i_fault_address,
    input  logic [tlpff_pkg::FRAME_W-1:0]  i_new_table_frame,
    input  logic [tlpff_pkg::FRAME_W-1:0]  i_new_page_frame,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [tlpff_pkg::ENTRY_W-1:0]  o_directory_entry,
    output logic [tlpff_pkg::ENTRY_W-1:0]  o_table_entry,
    output logic                           o_created_table,
    output logic                           o_window_error
);

    localparam int IDX_W     = tlpff_pkg::IDX_W;
    localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int TBL_DEPTH = TABLE_SLOTS * (2 ** IDX_W);
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    logic [tlpff_pkg::ENTRY_W-1:0] r_dir_mem [2**IDX_W];
    logic [tlpff_pkg::ENTRY_W-1:0] r_tbl_mem [TBL_DEPTH];

    logic [IDX_W-1:0]               r_cnt;
    logic                           r_op;
    logic [IDX_W-1:0]               r_di;
    logic [IDX_W-1:0]               r_ti;
    logic [tlpff_pkg::FRAME_W-1:0]  r_tframe;
    logic [tlpff_pkg::FRAME_W-1:0]  r_pframe;
    logic [tlpff_pkg::ENTRY_W-1:0]  r_dir_q;
    logic [tlpff_pkg::ENTRY_W-1:0]  r_tbl_q;
    logic [SLOT_W-1:0]              r_slot;
    logic [tlpff_pkg::ENTRY_W-1:0]  r_de;
    logic [tlpff_pkg::ENTRY_W-1:0]  r_te;
    logic                           r_created;
    logic                           r_err;
    logic                           r_out_valid;
    logic [tlpff_pkg::ENTRY_W-1:0]  r_out_de;
    logic [tlpff_pkg::ENTRY_W-1:0]  r_out_te;
    logic                           r_out_created;
    logic                           r_out_err;

    logic                           w_present;
    logic                           w_fill;
    logic [tlpff_pkg::FRAME_W-1:0]  w_frame;
    logic [tlpff_pkg::FRAME_W-1:0]  w_off;
    logic                           w_in_window;
    logic [tlpff_pkg::ENTRY_W-1:0]  w_map_entry;
    logic [tlpff_pkg::ENTRY_W-1:0]  w_new_de;

    logic                           w_dir_we;
    logic [IDX_W-1:0]               w_dir_waddr;
    logic [tlpff_pkg::ENTRY_W-1:0]  w_dir_wdata;
    logic                           w_tbl_we;
    logic [SLOT_W-1:0]              w_tbl_wslot;
    logic [IDX_W-1:0]               w_tbl_widx;
    logic [TBL_AW-1:0]              w_tbl_waddr;
    logic [tlpff_pkg::ENTRY_W-1:0]  w_tbl_wdata;
    logic [TBL_AW-1:0]              w_tbl_raddr;

    // Window check on the frame the item needs: the stored one when present,
    // otherwise the supplied new table frame.
    assign w_present   = r_dir_q[0];
    assign w_fill      = (r_op == tlpff_pkg::OP_FILL);
    assign w_frame     = w_present ? r_dir_q[31:12] : r_tframe;
    assign w_off       = w_frame - i_base;
    assign w_in_window = (w_frame >= i_base) && (w_off < tlpff_pkg::FRAME_W'(TABLE_SLOTS));
    assign w_map_entry = {r_pframe, tlpff_pkg::FLAGS_PRESENT_RW};
    assign w_new_de    = {r_tframe, tlpff_pkg::FLAGS_PRESENT_RW};

    assign o_stat.cnt_last  = &r_cnt;
    assign o_stat.present   = w_present;
    assign o_stat.in_window = w_in_window;
    assign o_stat.fill      = w_fill;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        w_dir_we    = i_cmd.init_wr || (i_cmd.map_wr && r_created);
        w_dir_waddr = r_di;
        w_dir_wdata = r_de;
        if (i_cmd.init_wr) begin
            w_dir_waddr = r_cnt;
            w_dir_wdata = (r_cnt == '0) ? tlpff_pkg::RESET_DIR0 : tlpff_pkg::ENTRY_ABSENT;
        end
    end

    always_comb begin
        w_tbl_we    = i_cmd.init_wr || i_cmd.clr_wr || i_cmd.map_wr;
        w_tbl_wslot = r_slot;
        w_tbl_widx  = r_ti;
        w_tbl_wdata = w_map_entry;
        if (i_cmd.init_wr) begin
            // Slot 0 starts as the identity map of the first 4 MiB.
            w_tbl_wslot = '0;
            w_tbl_widx  = r_cnt;
            w_tbl_wdata = tlpff_pkg::ENTRY_W'({r_cnt, tlpff_pkg::FLAGS_PRESENT_RW});
        end else if (i_cmd.clr_wr) begin
            w_tbl_widx  = r_cnt;
            w_tbl_wdata = tlpff_pkg::ENTRY_ABSENT;
        end
    end

    assign w_tbl_waddr = TBL_AW'({w_tbl_wslot, w_tbl_widx});
    assign w_tbl_raddr = TBL_AW'({r_slot, r_ti});

    always_ff @(posedge i_clk) begin
        if (w_dir_we) begin
            r_dir_mem[w_dir_waddr] <= w_dir_wdata;
        end
        if (i_cmd.dir_rd) begin
            r_dir_q <= r_dir_mem[r_di];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_tbl_mem[w_tbl_waddr] <= w_tbl_wdata;
        end
        if (i_cmd.tbl_rd) begin
            r_tbl_q <= r_tbl_mem[w_tbl_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_operation;
            r_di     <= i_fault_address[31:22];
            r_ti     <= i_fault_address[21:12];
            r_tframe <= i_new_table_frame;
            r_pframe <= i_new_page_frame;
        end
        if (i_cmd.eval) begin
            r_slot    <= w_off[SLOT_W-1:0];
            r_err     <= (w_present || w_fill) && !w_in_window;
            r_created <= !w_present && w_fill && w_in_window;
            r_de      <= (!w_present && w_fill && w_in_window) ? w_new_de : r_dir_q;
            r_te      <= '0;
        end else if (i_cmd.map_wr) begin
            r_te <= w_map_entry;
        end else if (i_cmd.te_cap) begin
            r_te <= r_tbl_q;
        end
    end

    // Result register: a finished item waits here while the next one is taken in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_de      <= r_de;
            r_out_te      <= r_te;
            r_out_created <= r_created;
            r_out_err     <= r_err;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_directory_entry = r_out_de;
    assign o_table_entry     = r_out_te;
    assign o_created_table   = r_out_created;
    assign o_window_error    = r_out_err;

endmodule

[src/two_level_page_fault_filler_core.sv]
// Page fault filler keeps an x86-style page directory (1024 entries) and a window of
// TABLE_SLOTS page tables in on-chip memories, and fills or translates one address per
// item. After reset a sweep writes the directory defaults and the identity table of
// slot 0; no item is taken during it, configuration writes are. A translate of a present
// entry reads the directory and then the table entry; a fault on a present entry writes
// the page mapping; a translate of an absent entry or a window error ends at the directory
// check. A fault that must create a table first clears the new table through the single
// write port of the table memory, one entry a cycle. One item is worked on at a time, and
// the input is ready again in the cycle after the result is loaded. The next item is accepted
// while the previous result waits in the output register; a finished item whose result
// register is still full holds the block until the result is taken.
// Depends on tlpff_pkg, tlpff_in_if, tlpff_out_if, tlpff_ctrl and tlpff_dpath.
module two_level_page_fault_filler_core #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tlpff_in_if.sink     i_in,
    tlpff_out_if.source  o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [tlpff_pkg::FRAME_W-1:0] r_table_frame_base;
    tlpff_pkg::t_cmd               w_cmd;
    tlpff_pkg::t_stat              w_stat;
    logic                          w_in_ready;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_frame_base <= tlpff_pkg::RESET_BASE;
        end else if (psel && penable && pwrite &&
                     (paddr[2] == tlpff_pkg::REG_TABLE_FRAME_BASE)) begin
            r_table_frame_base <= pwdata[tlpff_pkg::FRAME_W-1:0];
        end
    end

    assign prdata = (paddr[2] == tlpff_pkg::REG_TABLE_FRAME_BASE) ?
                    32'(r_table_frame_base) : 32'h0;

    assign i_in.ready = w_in_ready;

    tlpff_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tlpff_dpath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_base            (r_table_frame_base),
        .i_operation       (i_in.operation),
        .i_fault_address   (i_in.fault_address),
        .i_new_table_frame (i_in.new_table_frame),
        .i_new_page_frame  (i_in.new_page_frame),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_directory_entry (o_out.directory_entry),
        .o_table_entry     (o_out.table_entry),
        .o_created_table   (o_out.created_table),
        .o_window_error    (o_out.window_error)
    );

endmodule
